@@ sv/bmh_pkg.sv @@
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } res_t;

endpackage

@@ sv/bmh_ram.sv @@
// ----------------------------------------------------------------------------
// bmh_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bmh_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmh_ctrl
// Heap sequencer: sift-up for insert, sift-down for delete, at most one RAM access
// per cycle. The moving entry is held in a register (hole method) and written
// once at its final slot; the root is mirrored in a register.
// ----------------------------------------------------------------------------
module bmh_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  bmh_pkg::cmd_t                     cmd,
    output logic                              busy,
    output logic                              fin_valid,
    input  logic                              fin_ready,
    output bmh_pkg::res_t                     fin,
    output logic                              rd_en,
    output logic [$clog2(CAPACITY)-1:0]       rd_addr,
    input  logic [bmh_pkg::DATA_W-1:0]        rd_data,
    output logic                              wr_en,
    output logic [$clog2(CAPACITY)-1:0]       wr_addr,
    output logic [bmh_pkg::DATA_W-1:0]        wr_data
);

    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP     = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_LAST   = 8'b0000_1000,
        S_DN     = 8'b0001_0000,
        S_DN_R   = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic signed [DATA_W-1:0]  left_reg, left_next;
    logic                      right_ok_reg, right_ok_next;
    logic signed [DATA_W-1:0]  removed_reg, removed_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [DATA_W-1:0]  root_reg, root_next;

    logic [CW:0]               left_pos;
    logic [CW:0]               right_pos;
    logic [CW:0]               cnt_ext;
    logic [CW-1:0]             parent_pos;
    logic signed [DATA_W-1:0]  child_val;
    logic [CW-1:0]             child_pos;
    logic                      pick_right;

    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign cnt_ext    = {1'b0, cnt_reg};
    assign parent_pos = pos_reg >> 1;

    // in S_DN_CMP rd_data holds the right child when one was read
    assign pick_right = right_ok_reg && ($signed(rd_data) > left_reg);
    assign child_val  = pick_right ? $signed(rd_data) : left_reg;
    assign child_pos  = pick_right ? CW'(right_pos) : CW'(left_pos);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        left_next     = left_reg;
        right_ok_next = right_ok_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        root_next     = root_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    status_next  = ST_DONE;
                    if (cmd.command == CMD_INSERT)
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            pos_next   = cnt_reg + 1'b1;
                            val_next   = cmd.value;
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // fetch the last entry; it is sifted down from the root
                            removed_next = root_reg;
                            cnt_next     = cnt_reg - 1'b1;
                            pos_next     = CW'(1);
                            rd_en        = 1'b1;
                            rd_addr      = AW'(cnt_reg - 1'b1);
                            state_next   = S_LAST;
                        end
                    end
                end
            end

            S_UP:
            begin
                if (pos_reg == CW'(1))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(parent_pos - 1'b1);
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - 1'b1);
                if (val_reg > $signed(rd_data))
                begin
                    // parent moves down into the hole
                    wr_data    = rd_data;
                    pos_next   = parent_pos;
                    state_next = S_UP;
                end
                else
                begin
                    wr_data    = val_reg;
                    state_next = S_DONE;
                end
            end

            S_LAST:
            begin
                val_next   = $signed(rd_data);
                state_next = S_DN;
            end

            S_DN:
            begin
                if (left_pos > cnt_ext)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(pos_reg - 1'b1);
                    wr_data    = val_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(left_pos - 1'b1);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                left_next     = $signed(rd_data);
                right_ok_next = (right_pos <= cnt_ext);
                if (right_pos <= cnt_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(right_pos - 1'b1);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - 1'b1);
                if (child_val > val_reg)
                begin
                    // larger child moves up into the hole
                    wr_data    = child_val;
                    pos_next   = child_pos;
                    state_next = S_DN;
                end
                else
                begin
                    wr_data    = val_reg;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (fin_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // keep the root mirror in step with slot 1
        if (wr_en && (wr_addr == '0))
        begin
            root_next = $signed(wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        left_reg     <= left_next;
        right_ok_reg <= right_ok_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        root_reg     <= root_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign fin_valid = (state_reg == S_DONE);

    always_comb
    begin
        fin.removed_value = removed_reg;
        fin.top_value     = (cnt_reg != '0) ? root_reg : '0;
        fin.top_valid     = (cnt_reg != '0);
        fin.count         = COUNT_W'(cnt_reg);
        fin.status        = status_reg;
    end

endmodule

@@ sv/binary_max_heap_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_top
// Max-priority queue on a binary heap held in one synchronous RAM.
//
//   channel  valid      stall      payload  contents
//   command  cmd_valid  cmd_stall  cmd      command, value
//   result   res_valid  res_stall  res      removed/top value, count, status
//
// One command at a time, one result each.
// Insert: sift-up; per level, read the parent, then compare and write the hole.
// Delete: read the last entry, then sift-down; per level, read left, read right,
// compare/write; paced by the single RAM read port. Refused: straight to done.
// Reset clears control state and the count; heap RAM contents need no clearing.
// A command can transfer while the previous result waits; a stalled result holds the
// sequencer in its final state.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bmh_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output bmh_pkg::res_t res
);

    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              start;
    logic              busy;
    logic              fin_valid;
    logic              fin_ready;
    res_t              fin;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic              res_valid_reg;
    res_t              res_reg;

    assign cmd_stall = busy;
    assign start     = cmd_valid && !busy;
    assign fin_ready = !res_valid_reg || !res_stall;

    bmh_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    bmh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fin_valid && fin_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            res_reg <= fin;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // an accepted command always occupies the sequencer in the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall
    ) else $error("sequencer idle right after a command transfer");

    a_empty_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ST_EMPTY)) |->
            (!res.top_valid && (res.removed_value == '0))
    ) else $error("delete on empty reported data");

    a_full_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ST_FULL)) |-> res.top_valid
    ) else $error("full insert refusal with empty heap");

    // a new result is only loaded when the output register is free
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> $stable(res)
    ) else $error("stalled result overwritten");

endmodule
